### hdl/button_matrix_event_detector_top_macros.svh
// Assertion macros for the button matrix event detector.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef BUTTON_MATRIX_EVENT_DETECTOR_TOP_MACROS_SVH
`define BUTTON_MATRIX_EVENT_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BMED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bmed_pkg.sv
// Shared types and constants for the button matrix event detector.
// No dependencies; imported by all bmed modules and the top level.
`default_nettype none

package bmed_pkg;

   localparam int LANES            = 8;
   localparam int LANE_W           = 3;
   localparam int BUTTON_COUNT_DEF = 128;
   localparam int BYTE_IDX_W       = 4;
   localparam int RAW_W            = 8;
   localparam int STAMP_W          = 32;
   localparam int BTN_W            = 7;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 16;
   localparam int REQ_DATA_W       = 48;
   localparam int RSP_DATA_W       = 24;

   localparam logic [7:0]  DEBOUNCE_RST    = 8'd12;
   localparam logic [15:0] HOLD_DELAY_RST  = 16'd500;
   localparam logic [7:0]  NOTE_START_RST  = 8'd16;
   localparam logic [7:0]  VERT_START_RST  = 8'd32;
   localparam logic [7:0]  HORIZ_START_RST = 8'd34;
   localparam logic [7:0]  DATA_START_RST  = 8'd36;
   localparam logic [7:0]  MODE_START_RST  = 8'd44;
   localparam logic [7:0]  EXTRA_START_RST = 8'd52;

   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_HOLD    = 2'd1,
      EV_RELEASE = 2'd2
   } event_kind_type;

   typedef enum logic [2:0] {
      KS_STEP       = 3'd0,
      KS_NOTE       = 3'd1,
      KS_VERTICAL   = 3'd2,
      KS_HORIZONTAL = 3'd3,
      KS_DATA       = 3'd4,
      KS_MODE       = 3'd5,
      KS_EXTRA      = 3'd6
   } key_set_type;

   typedef enum logic [2:0] {
      CSR_DEBOUNCE    = 3'd0,
      CSR_HOLD_DELAY  = 3'd1,
      CSR_NOTE_START  = 3'd2,
      CSR_VERT_START  = 3'd3,
      CSR_HORIZ_START = 3'd4,
      CSR_DATA_START  = 3'd5,
      CSR_MODE_START  = 3'd6,
      CSR_EXTRA_START = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                fired;
      logic                pressed;
      logic [STAMP_W-1:0]  stamp;
   } lane_state_type;

   typedef lane_state_type [LANES-1:0] lane_row_type;

   typedef struct packed {
      logic           fire;
      event_kind_type kind;
      logic           held;
   } lane_event_type;

   typedef struct packed {
      logic [BYTE_IDX_W-1:0]      byte_index;
      lane_event_type [LANES-1:0] ev;
   } event_bundle_type;

   typedef struct packed {
      logic [7:0] note_start;
      logic [7:0] vert_start;
      logic [7:0] horiz_start;
      logic [7:0] data_start;
      logic [7:0] mode_start;
      logic [7:0] extra_start;
   } key_starts_type;

   typedef struct packed {
      logic [7:0]     debounce_ms;
      logic [15:0]    hold_delay_ms;
      key_starts_type starts;
   } csr_type;

endpackage

`default_nettype wire

### hdl/button_matrix_event_detector_top.sv
// Button matrix event detector: top level with the per-row state memory, the lane
// array and the config registers. Depends on bmed_pkg, bmed_lane, bmed_merge and the
// assertion macros header.
//
// Usage:
//   req channel: one scanned byte per transaction (byte_index, raw_bits active low,
//   now_ms). Eight lanes judge the eight buttons of that byte in the same cycle and
//   write the row of button state back.
//   rsp channel: one event per transaction, in bit order; tlast marks the final
//   event of a byte. A byte that causes no event gives no transaction.
//   csr port: csr_we / csr_addr / csr_wdata write a register at once; write only
//   while idle.
//   Path of a byte: req -> stage-1 regs -> merge pending reg -> output reg -> rsp.
//   Throughput: the single-event output port of the merge stage holds a byte with
//   several events until its last event is out; bytes with at most one event
//   stream at one per cycle while rsp_tready stays high.
//   Reset: state rows are marked invalid at once (read as all zero), config
//   returns to its defaults; no clearing pass.
//   Stall: with rsp_tready low the output register holds, the merge stage fills,
//   then req_tready drops; nothing is lost.
`default_nettype none

`include "button_matrix_event_detector_top_macros.svh"

module button_matrix_event_detector_top
   import bmed_pkg::*;
#(
   parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata, from bit 0: byte_index[3:0], raw_bits[7:0], now_ms[31:0], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata, from bit 0: button_number[6:0], event_kind[1:0], held_before,
   // key_set[2:0], index_in_set[6:0], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int Rows = (BUTTON_COUNT + LANES - 1) / LANES;
   localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;

   // config registers
   csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_DEBOUNCE:    csr_in.debounce_ms        = csr_wdata[7:0];
            CSR_HOLD_DELAY:  csr_in.hold_delay_ms      = csr_wdata;
            CSR_NOTE_START:  csr_in.starts.note_start  = csr_wdata[7:0];
            CSR_VERT_START:  csr_in.starts.vert_start  = csr_wdata[7:0];
            CSR_HORIZ_START: csr_in.starts.horiz_start = csr_wdata[7:0];
            CSR_DATA_START:  csr_in.starts.data_start  = csr_wdata[7:0];
            CSR_MODE_START:  csr_in.starts.mode_start  = csr_wdata[7:0];
            CSR_EXTRA_START: csr_in.starts.extra_start = csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.debounce_ms        <= DEBOUNCE_RST;
         csr_ff.hold_delay_ms      <= HOLD_DELAY_RST;
         csr_ff.starts.note_start  <= NOTE_START_RST;
         csr_ff.starts.vert_start  <= VERT_START_RST;
         csr_ff.starts.horiz_start <= HORIZ_START_RST;
         csr_ff.starts.data_start  <= DATA_START_RST;
         csr_ff.starts.mode_start  <= MODE_START_RST;
         csr_ff.starts.extra_start <= EXTRA_START_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // input fields
   logic [BYTE_IDX_W-1:0] req_byte;
   logic [RAW_W-1:0]      req_raw;
   logic [STAMP_W-1:0]    req_now;

   assign req_byte = req_tdata[3:0];
   assign req_raw  = req_tdata[11:4];
   assign req_now  = req_tdata[43:12];

   logic                  accept;
   logic [RowW-1:0]       rd_row;
   logic                  row_ok_in;
   logic                  rowvld_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [BYTE_IDX_W-1:0] s1_byte_ff;
   logic [RAW_W-1:0]      s1_raw_ff;
   logic [STAMP_W-1:0]    s1_now_ff;
   logic [RowW-1:0]       s1_row_ff;
   logic                  s1_row_ok_ff;
   logic                  s1_rowvld_ff;
   lane_row_type          mem_rd_ff;

   logic                  last_wr_vld_ff;
   logic [RowW-1:0]       last_wr_row_ff;
   lane_row_type          last_wr_data_ff;

   logic [Rows-1:0]       valid_ff;
   lane_row_type          row_mem [Rows];

   lane_row_type          src_row;
   lane_row_type          nxt_row;
   logic [LANES-1:0]      lane_en;
   logic [LANES-1:0]      ev_mask;
   event_bundle_type      bundle;
   logic                  bun_ready;
   logic                  s1_adv;
   logic                  mem_we;

   assign accept     = req_tvalid && req_tready;
   assign rd_row     = RowW'(req_byte);
   assign row_ok_in  = (int'(req_byte) * LANES) < BUTTON_COUNT;
   assign rowvld_in  = row_ok_in ? valid_ff[rd_row] : 1'b0;

   assign s1_adv     = s1_valid_ff && bun_ready;
   assign req_tready = !s1_valid_ff || bun_ready;
   assign mem_we     = s1_adv && s1_row_ok_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         last_wr_vld_ff <= 1'b0;
         valid_ff       <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (mem_we) begin
            last_wr_vld_ff      <= 1'b1;
            valid_ff[s1_row_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff   <= req_byte;
         s1_raw_ff    <= req_raw;
         s1_now_ff    <= req_now;
         s1_row_ff    <= rd_row;
         s1_row_ok_ff <= row_ok_in;
         s1_rowvld_ff <= rowvld_in;
      end
      if (mem_we) begin
         last_wr_row_ff  <= s1_row_ff;
         last_wr_data_ff <= nxt_row;
      end
   end

   // state memory, one row per scanned byte
   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[s1_row_ff] <= nxt_row;
      end
      if (accept) begin
         mem_rd_ff <= row_mem[rd_row];
      end
   end

   // the latest write to a row always wins over the memory read, which may be stale
   always_comb begin
      if (last_wr_vld_ff && (last_wr_row_ff == s1_row_ff)) begin
         src_row = last_wr_data_ff;
      end else if (s1_rowvld_ff) begin
         src_row = mem_rd_ff;
      end else begin
         src_row = '0;
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      assign lane_en[g] = s1_row_ok_ff && ((int'(s1_byte_ff) * LANES + g) < BUTTON_COUNT);

      bmed_lane u_lane (
         .en            (lane_en[g]),
         .down          (!s1_raw_ff[g]),
         .now_ms        (s1_now_ff),
         .debounce_ms   (csr_ff.debounce_ms),
         .hold_delay_ms (csr_ff.hold_delay_ms),
         .cur           (src_row[g]),
         .nxt           (nxt_row[g]),
         .ev            (bundle.ev[g])
      );

      assign ev_mask[g] = bundle.ev[g].fire;
   end

   assign bundle.byte_index = s1_byte_ff;

   bmed_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .starts     (csr_ff.starts),
      .in_valid   (s1_valid_ff),
      .in_ready   (bun_ready),
      .bundle     (bundle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `BMED_ASSERT_NOW(a_stall_needs_item, clock, reset, !req_tready, s1_valid_ff, "req stalled with empty stage")
   `BMED_ASSERT_NEXT(a_row_marked, clock, reset, mem_we, valid_ff[$past(s1_row_ff)], "written row not valid")
   `BMED_ASSERT_NOW(a_no_event_off_lane, clock, reset, s1_valid_ff, (ev_mask & ~lane_en) == '0, "event on disabled lane")

endmodule

`default_nettype wire

### hdl/bmed_lane.sv
// One button lane: press / hold / release decision and next state for one button.
// Depends on bmed_pkg.
`default_nettype none

module bmed_lane
   import bmed_pkg::*;
(
   input  logic                en,
   input  logic                down,
   input  logic [STAMP_W-1:0]  now_ms,
   input  logic [7:0]          debounce_ms,
   input  logic [15:0]         hold_delay_ms,
   input  lane_state_type      cur,
   output lane_state_type      nxt,
   output lane_event_type      ev
);

   logic [STAMP_W-1:0] elapsed;
   logic               past_deb;
   logic               past_hold;
   logic               press_ev;
   logic               hold_ev;
   logic               release_ev;

   // elapsed time wraps mod 2^32
   assign elapsed   = now_ms - cur.stamp;
   assign past_deb  = elapsed > {24'd0, debounce_ms};
   assign past_hold = elapsed > {16'd0, hold_delay_ms};

   assign press_ev   = en && down && !cur.pressed && past_deb;
   // a press restarts the stamp, and !press_ev gates hold_ev, so no hold in the same item
   assign hold_ev    = en && down && !press_ev && !cur.fired && past_hold;
   assign release_ev = en && !down && cur.pressed && past_deb;

   always_comb begin
      nxt     = cur;
      ev.fire = press_ev || hold_ev || release_ev;
      ev.kind = EV_PRESS;
      ev.held = 1'b0;
      if (press_ev) begin
         nxt.pressed = 1'b1;
         nxt.stamp   = now_ms;
      end
      if (hold_ev) begin
         nxt.fired = 1'b1;
         ev.kind   = EV_HOLD;
      end
      if (release_ev) begin
         nxt.pressed = 1'b0;
         nxt.fired   = 1'b0;
         nxt.stamp   = now_ms;
         ev.kind     = EV_RELEASE;
         ev.held     = cur.fired;
      end
   end

endmodule

`default_nettype wire

### hdl/bmed_merge.sv
// Merge stage: holds the lane events of one item, emits them in lane order one per
// cycle unless stalled, with key-set classification, registered. Depends on bmed_pkg.
`default_nettype none

module bmed_merge
   import bmed_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  key_starts_type        starts,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  event_bundle_type      bundle,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata, from bit 0: button_number[6:0], event_kind[1:0], held_before,
   // key_set[2:0], index_in_set[6:0], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic [LANES-1:0]      pend_mask_ff, pend_mask_in;
   event_bundle_type      pend_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic                  out_free;
   logic                  emit;
   logic                  load;
   logic [LANE_W-1:0]     sel;
   logic [LANES-1:0]      rest;
   logic [LANES-1:0]      in_mask;
   logic [BTN_W-1:0]      btn;
   logic [7:0]            num8;
   logic [7:0]            base;
   key_set_type           kset;
   logic [BTN_W-1:0]      idx;
   lane_event_type        cur_ev;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = out_free && (pend_mask_ff != '0);

   // lowest pending lane first
   always_comb begin
      sel = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (pend_mask_ff[i]) begin
            sel = LANE_W'(i);
         end
      end
   end

   assign rest     = pend_mask_ff & ~(LANES'(1) << sel);
   assign in_ready = (pend_mask_ff == '0) || (emit && (rest == '0));
   assign load     = in_valid && in_ready;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         in_mask[i] = bundle.ev[i].fire;
      end
   end

   assign btn    = {pend_ff.byte_index, sel};
   assign num8   = {1'b0, btn};
   assign cur_ev = pend_ff.ev[sel];

   always_comb begin
      priority if (num8 < starts.note_start) begin
         kset = KS_STEP;
         base = 8'd0;
      end else if (num8 < starts.vert_start) begin
         kset = KS_NOTE;
         base = starts.note_start;
      end else if (num8 < starts.horiz_start) begin
         kset = KS_VERTICAL;
         base = starts.vert_start;
      end else if (num8 < starts.data_start) begin
         kset = KS_HORIZONTAL;
         base = starts.horiz_start;
      end else if (num8 < starts.mode_start) begin
         kset = KS_DATA;
         base = starts.data_start;
      end else if (num8 < starts.extra_start) begin
         kset = KS_MODE;
         base = starts.mode_start;
      end else begin
         kset = KS_EXTRA;
         base = starts.extra_start;
      end
   end

   assign idx         = BTN_W'(num8 - base);
   assign rsp_data_in = RSP_DATA_W'({idx, kset, cur_ev.held, cur_ev.kind, btn});

   always_comb begin
      pend_mask_in = pend_mask_ff;
      if (load) begin
         pend_mask_in = in_mask;
      end else if (emit) begin
         pend_mask_in = rest;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_mask_ff <= pend_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pend_ff <= bundle;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= (rest == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
